@@ sv/pib_pkg.sv @@
// ----------------------------------------------------------------------------
// pib_pkg: shared definitions of the oriented-box point filter
// Field widths, request and register codes, box record and chain beat types.
// ----------------------------------------------------------------------------
package pib_pkg;

    localparam int MAX_BOXES_DEF = 32;
    localparam int SLOT_W        = 6;
    localparam int COORD_W       = 16;
    localparam int LEN_W         = 12;
    localparam int TRIG_W        = 16;
    localparam int CFG_W         = 8;
    localparam int CRN_W         = 17;
    localparam int QLEN_W        = 13;
    localparam int PROD_W        = 30;
    localparam int ACC_W         = 33;
    localparam int MASK_W        = 32;
    localparam int CNT_OUT_W     = 6;
    localparam int APB_AW        = 5;
    localparam int APB_DW        = 32;

    localparam logic [1:0] REQ_CLEAR = 2'd0;
    localparam logic [1:0] REQ_LOAD  = 2'd1;
    localparam logic [1:0] REQ_POINT = 2'd2;
    localparam logic [1:0] REQ_RSVD  = 2'd3;

    localparam logic [2:0] REG_QUANT_STEP     = 3'd0;
    localparam logic [2:0] REG_WIDTH_ENLARGE  = 3'd1;
    localparam logic [2:0] REG_LENGTH_ENLARGE = 3'd2;
    localparam logic [2:0] REG_BOTTOM_MARGIN  = 3'd3;
    localparam logic [2:0] REG_TOP_MARGIN     = 3'd4;

    typedef logic [CRN_W-1:0] crn_t;

    typedef struct packed {
        crn_t [3:0]         cx;
        crn_t [3:0]         cy;
        crn_t               xmin;
        crn_t               xmax;
        crn_t               ymin;
        crn_t               ymax;
        logic [COORD_W-1:0] zc;
        logic [LEN_W-1:0]   h;
    } box_t;

    typedef struct packed {
        logic               vld;
        logic               is_load;
        logic [SLOT_W-1:0]  slot;
        logic [COORD_W-1:0] px;
        logic [COORD_W-1:0] py;
        logic [COORD_W-1:0] pz;
        box_t               box;
    } tok_t;

endpackage

@@ sv/pib_if.sv @@
// ----------------------------------------------------------------------------
// pib_if: request and result channels of the oriented-box point filter
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface pib_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic [11:0] box_width;
    logic [11:0] box_length;
    logic [11:0] box_height;
    logic signed [15:0] heading_cos;
    logic signed [15:0] heading_sin;

    modport source (
        output valid, req_type, pos_x, pos_y, pos_z, box_width, box_length,
               box_height, heading_cos, heading_sin,
        input  ready
    );
    modport sink (
        input  valid, req_type, pos_x, pos_y, pos_z, box_width, box_length,
               box_height, heading_cos, heading_sin,
        output ready
    );
endinterface

interface pib_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] hit_mask;
    logic [5:0]  boxes_stored;
    logic        load_dropped;

    modport source (
        output valid, hit_mask, boxes_stored, load_dropped,
        input  ready
    );
    modport sink (
        input  valid, hit_mask, boxes_stored, load_dropped,
        output ready
    );
endinterface

@@ sv/pib_box_prep.sv @@
// ----------------------------------------------------------------------------
// pib_box_prep: box setup sequencer
// Rounds width and length up to the step with a bit-serial divider (a zero step
// keeps them), adds the enlarge values, rotates the half extents and forms corners
// and bounds.
module pib_box_prep
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [pib_pkg::COORD_W-1:0]  pos_x,
    input  logic signed [pib_pkg::COORD_W-1:0]  pos_y,
    input  logic signed [pib_pkg::COORD_W-1:0]  pos_z,
    input  logic [pib_pkg::LEN_W-1:0]           box_width,
    input  logic [pib_pkg::LEN_W-1:0]           box_length,
    input  logic [pib_pkg::LEN_W-1:0]           box_height,
    input  logic signed [pib_pkg::TRIG_W-1:0]   heading_cos,
    input  logic signed [pib_pkg::TRIG_W-1:0]   heading_sin,
    input  logic [pib_pkg::CFG_W-1:0]           quant_step,
    input  logic [pib_pkg::CFG_W-1:0]           width_enlarge,
    input  logic [pib_pkg::CFG_W-1:0]           length_enlarge,
    output logic                                done,
    output pib_pkg::box_t                       box
);

    typedef enum logic [2:0] {P_IDLE, P_DIV, P_QUANT, P_MUL, P_CORNER, P_BOUND} pstate_t;

    localparam int QW = pib_pkg::QLEN_W;
    localparam int PW = pib_pkg::PROD_W;
    localparam int AW = pib_pkg::ACC_W;
    localparam int CW = pib_pkg::CRN_W;
    localparam int DIV_LAST = QW - 1;

    pstate_t state_reg;
    logic    done_reg;
    logic [3:0] cnt_reg;

    logic signed [pib_pkg::COORD_W-1:0] x_reg, y_reg, z_reg;
    logic [pib_pkg::LEN_W-1:0]          w_reg, l_reg, h_reg;
    logic signed [pib_pkg::TRIG_W-1:0]  c_reg, s_reg;
    logic [pib_pkg::CFG_W-1:0]          q_reg, we_reg, le_reg;

    logic [QW-1:0] wdq_reg, ldq_reg;
    logic [pib_pkg::CFG_W-1:0] wrem_reg, lrem_reg;
    logic [QW-1:0] wf_reg, lf_reg;
    logic signed [PW-1:0] wc_reg, ws_reg, lc_reg, ls_reg;
    logic signed [CW-1:0] cx_reg [4];
    logic signed [CW-1:0] cy_reg [4];
    pib_pkg::box_t box_reg;

    // Divider step for width and length
    logic [pib_pkg::CFG_W:0] wtrial, ltrial;
    logic wbit, lbit;
    logic [pib_pkg::CFG_W-1:0] wrem_next, lrem_next;
    logic [QW+pib_pkg::CFG_W-1:0] wprod, lprod;
    logic [QW-1:0] wq, lq;
    logic signed [AW-1:0] xs, ys, wc33, ws33, lc33, ls33;
    logic signed [AW-1:0] sx [4];
    logic signed [AW-1:0] sy [4];
    logic signed [CW-1:0] xmin, xmax, ymin, ymax;

    function automatic logic signed [CW-1:0] rnd(input logic signed [AW-1:0] v);
        logic signed [AW-1:0] t;
        t = v + AW'(16384);
        return t[AW-2:15];
    endfunction

    always_comb
    begin
        wtrial    = {wrem_reg, wdq_reg[QW-1]};
        ltrial    = {lrem_reg, ldq_reg[QW-1]};
        wbit      = (wtrial >= {1'b0, q_reg});
        lbit      = (ltrial >= {1'b0, q_reg});
        wrem_next = wbit ? pib_pkg::CFG_W'(wtrial - {1'b0, q_reg}) : wtrial[pib_pkg::CFG_W-1:0];
        lrem_next = lbit ? pib_pkg::CFG_W'(ltrial - {1'b0, q_reg}) : ltrial[pib_pkg::CFG_W-1:0];

        wprod = wdq_reg * q_reg;
        lprod = ldq_reg * q_reg;
        wq = (q_reg == '0) ? QW'(w_reg) : wprod[QW-1:0];
        lq = (q_reg == '0) ? QW'(l_reg) : lprod[QW-1:0];

        xs   = {{2{x_reg[pib_pkg::COORD_W-1]}}, x_reg, 15'b0};
        ys   = {{2{y_reg[pib_pkg::COORD_W-1]}}, y_reg, 15'b0};
        wc33 = AW'(wc_reg);
        ws33 = AW'(ws_reg);
        lc33 = AW'(lc_reg);
        ls33 = AW'(ls_reg);
        sx[0] = -wc33 - ls33 + xs;  sy[0] =  ws33 - lc33 + ys;
        sx[1] = -wc33 + ls33 + xs;  sy[1] =  ws33 + lc33 + ys;
        sx[2] =  wc33 + ls33 + xs;  sy[2] = -ws33 + lc33 + ys;
        sx[3] =  wc33 - ls33 + xs;  sy[3] = -ws33 - lc33 + ys;

        xmin = cx_reg[0]; xmax = cx_reg[0];
        ymin = cy_reg[0]; ymax = cy_reg[0];
        for (int i = 1; i < 4; i++)
        begin
            if (cx_reg[i] < xmin) xmin = cx_reg[i];
            if (cx_reg[i] > xmax) xmax = cx_reg[i];
            if (cy_reg[i] < ymin) ymin = cy_reg[i];
            if (cy_reg[i] > ymax) ymax = cy_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= P_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                P_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= P_DIV;
                        cnt_reg   <= '0;
                    end
                end
                P_DIV:
                begin
                    cnt_reg <= cnt_reg + 4'd1;
                    if (cnt_reg == 4'(DIV_LAST))
                        state_reg <= P_QUANT;
                end
                P_QUANT:  state_reg <= P_MUL;
                P_MUL:    state_reg <= P_CORNER;
                P_CORNER: state_reg <= P_BOUND;
                P_BOUND:
                begin
                    state_reg <= P_IDLE;
                    done_reg  <= 1'b1;
                end
                default:  state_reg <= P_IDLE;
            endcase
        end
    end

    // Datapath registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (state_reg == P_IDLE && start)
        begin
            x_reg  <= pos_x;       y_reg <= pos_y;       z_reg <= pos_z;
            w_reg  <= box_width;   l_reg <= box_length;  h_reg <= box_height;
            c_reg  <= heading_cos; s_reg <= heading_sin;
            q_reg  <= quant_step;
            we_reg <= width_enlarge;
            le_reg <= length_enlarge;
            // Ceiling division: divide len + step - 1 by the step.
            wdq_reg  <= QW'({1'b0, box_width}  + {5'b0, quant_step} - 13'd1);
            ldq_reg  <= QW'({1'b0, box_length} + {5'b0, quant_step} - 13'd1);
            wrem_reg <= '0;
            lrem_reg <= '0;
        end
        if (state_reg == P_DIV)
        begin
            wdq_reg  <= {wdq_reg[QW-2:0], wbit};
            ldq_reg  <= {ldq_reg[QW-2:0], lbit};
            wrem_reg <= wrem_next;
            lrem_reg <= lrem_next;
        end
        if (state_reg == P_QUANT)
        begin
            wf_reg <= wq + QW'(we_reg);
            lf_reg <= lq + QW'(le_reg);
        end
        if (state_reg == P_MUL)
        begin
            wc_reg <= PW'($signed({1'b0, wf_reg}) * c_reg);
            ws_reg <= PW'($signed({1'b0, wf_reg}) * s_reg);
            lc_reg <= PW'($signed({1'b0, lf_reg}) * c_reg);
            ls_reg <= PW'($signed({1'b0, lf_reg}) * s_reg);
        end
        if (state_reg == P_CORNER)
        begin
            for (int i = 0; i < 4; i++)
            begin
                cx_reg[i] <= rnd(sx[i]);
                cy_reg[i] <= rnd(sy[i]);
            end
        end
        if (state_reg == P_BOUND)
        begin
            for (int i = 0; i < 4; i++)
            begin
                box_reg.cx[i] <= cx_reg[i];
                box_reg.cy[i] <= cy_reg[i];
            end
            box_reg.xmin <= xmin;
            box_reg.xmax <= xmax;
            box_reg.ymin <= ymin;
            box_reg.ymax <= ymax;
            box_reg.zc   <= z_reg;
            box_reg.h    <= h_reg;
        end
    end

    assign done = done_reg;
    assign box  = box_reg;

endmodule

@@ sv/pib_cell.sv @@
// ----------------------------------------------------------------------------
// pib_cell: one box slot of the filter chain
// Holds one box, passes each beat to its neighbor, and tests points in a
// three-stage pipeline: bounds, height band and edge differences; cross-products; sign test.
// ----------------------------------------------------------------------------
module pib_cell
#(
    parameter int INDEX = 0
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  pib_pkg::tok_t                 tok_in,
    input  logic [pib_pkg::CFG_W-1:0]     bottom_margin,
    input  logic [pib_pkg::CFG_W-1:0]     top_margin,
    output pib_pkg::tok_t                 tok_out,
    output logic                          hit
);

    localparam int CW = pib_pkg::CRN_W;
    localparam int DW = CW + 1;
    localparam int MW = 2 * DW;
    localparam int HW = 20;

    pib_pkg::tok_t tok_reg;
    pib_pkg::box_t box_reg;

    logic                 a_ok_reg;
    logic signed [DW-1:0] dx_reg [4];
    logic signed [DW-1:0] dy_reg [4];
    logic signed [DW-1:0] ex_reg [4];
    logic signed [DW-1:0] ey_reg [4];
    logic                 b_ok_reg;
    logic signed [MW-1:0] p1_reg [4];
    logic signed [MW-1:0] p2_reg [4];
    logic                 hit_reg;

    logic signed [CW-1:0] px, py;
    logic signed [HW-1:0] pz2, zc2, hh, lo, hi;
    logic                 in_bnd, in_hgt;
    logic signed [DW-1:0] dx [4];
    logic signed [DW-1:0] dy [4];
    logic signed [DW-1:0] ex [4];
    logic signed [DW-1:0] ey [4];
    logic signed [MW:0]   cr [4];
    logic                 all_le, all_ge;

    always_comb
    begin
        px = CW'($signed(tok_in.px));
        py = CW'($signed(tok_in.py));
        in_bnd = (px >= $signed(box_reg.xmin)) && (px <= $signed(box_reg.xmax)) &&
                 (py >= $signed(box_reg.ymin)) && (py <= $signed(box_reg.ymax));
        // Height band compared at doubled scale so that half the height is exact.
        pz2 = HW'($signed({tok_in.pz, 1'b0}));
        zc2 = HW'($signed({box_reg.zc, 1'b0}));
        hh  = HW'({1'b0, box_reg.h});
        lo  = zc2 - hh - HW'({1'b0, bottom_margin, 1'b0});
        hi  = zc2 + hh + HW'({1'b0, top_margin, 1'b0});
        in_hgt = (pz2 >= lo) && (pz2 <= hi);
        for (int e = 0; e < 4; e++)
        begin
            dx[e] = DW'(px) - DW'($signed(box_reg.cx[e]));
            dy[e] = DW'(py) - DW'($signed(box_reg.cy[e]));
            ex[e] = DW'($signed(box_reg.cx[(e + 1) % 4])) - DW'($signed(box_reg.cx[e]));
            ey[e] = DW'($signed(box_reg.cy[(e + 1) % 4])) - DW'($signed(box_reg.cy[e]));
        end
        all_le = 1'b1;
        all_ge = 1'b1;
        for (int e = 0; e < 4; e++)
        begin
            cr[e] = (MW + 1)'(p1_reg[e]) - (MW + 1)'(p2_reg[e]);
            if (cr[e] > 0) all_le = 1'b0;
            if (cr[e] < 0) all_ge = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tok_reg <= '0;
        else
            tok_reg <= tok_in;
    end

    always_ff @(posedge clk)
    begin
        if (tok_in.vld && tok_in.is_load && tok_in.slot == INDEX[pib_pkg::SLOT_W-1:0])
            box_reg <= tok_in.box;
        a_ok_reg <= in_bnd && in_hgt;
        for (int e = 0; e < 4; e++)
        begin
            dx_reg[e] <= dx[e];
            dy_reg[e] <= dy[e];
            ex_reg[e] <= ex[e];
            ey_reg[e] <= ey[e];
            p1_reg[e] <= dx_reg[e] * ey_reg[e];
            p2_reg[e] <= dy_reg[e] * ex_reg[e];
        end
        b_ok_reg <= a_ok_reg;
        hit_reg  <= b_ok_reg && (all_le || all_ge);
    end

    assign tok_out = tok_reg;
    assign hit     = hit_reg;

endmodule

@@ sv/point_in_oriented_box_filter.sv @@
// Clear and reserved requests go straight to the result, as does a load into a full table;
// points walk the chain of box cells; box loads first pass the 13-step width/length divider
// and setup, then walk the chain.
// One request is in flight at a time; the next one is taken while a result waits.
// Reset (asynchronous, active low) empties the table and restores the registers.
// ----------------------------------------------------------------------------
// point_in_oriented_box_filter: top level
// Register file, request sequencer, box setup unit and the row of box cells.
// ----------------------------------------------------------------------------
module point_in_oriented_box_filter
#(
    parameter int MAX_BOXES = pib_pkg::MAX_BOXES_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    pib_in_if.sink                      in_ch,
    pib_out_if.source                   out_ch,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pib_pkg::APB_AW-1:0]  paddr,
    input  logic [pib_pkg::APB_DW-1:0]  pwdata,
    output logic [pib_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);

    typedef enum logic [1:0] {S_IDLE, S_PREP, S_CHAIN, S_DONE} state_t;

    localparam int TOT_W    = $clog2(MAX_BOXES + 1);
    localparam int WCNT_W   = $clog2(MAX_BOXES + 3);
    localparam int WAIT_END = MAX_BOXES + 2;
    localparam int MW       = pib_pkg::MASK_W;

    state_t state_reg;
    logic [TOT_W-1:0]  total_reg;
    logic [WCNT_W-1:0] wcnt_reg;
    logic              is_point_reg;
    logic [pib_pkg::COORD_W-1:0] px_reg, py_reg, pz_reg;
    logic [MW-1:0]     res_mask_reg;
    logic              res_drop_reg;
    logic              out_vld_reg;
    logic [MW-1:0]     out_mask_reg;
    logic [pib_pkg::CNT_OUT_W-1:0] out_cnt_reg;
    logic              out_drop_reg;
    pib_pkg::tok_t     launch_reg;

    logic [pib_pkg::CFG_W-1:0] quant_step_reg, width_enlarge_reg, length_enlarge_reg;
    logic [pib_pkg::CFG_W-1:0] bottom_margin_reg, top_margin_reg;

    logic          accept, full, prep_start, prep_done, cfg_wr;
    pib_pkg::box_t prep_box;
    pib_pkg::tok_t chain [MAX_BOXES + 1];
    logic [MAX_BOXES-1:0] hit_vec;
    logic [MW-1:0] hit_mask;
    logic [6:0]    tot7;
    logic [2:0]    reg_idx;

    assign accept     = in_ch.valid && in_ch.ready;
    assign full       = (total_reg >= TOT_W'(MAX_BOXES));
    assign prep_start = accept && (in_ch.req_type == pib_pkg::REQ_LOAD) && !full;
    assign in_ch.ready = (state_reg == S_IDLE);
    assign reg_idx    = paddr[4:2];
    assign cfg_wr     = psel && penable && pwrite;
    assign pready     = 1'b1;
    assign tot7       = 7'(total_reg);

    always_comb
    begin
        unique case (reg_idx)
            pib_pkg::REG_QUANT_STEP:     prdata = 32'(quant_step_reg);
            pib_pkg::REG_WIDTH_ENLARGE:  prdata = 32'(width_enlarge_reg);
            pib_pkg::REG_LENGTH_ENLARGE: prdata = 32'(length_enlarge_reg);
            pib_pkg::REG_BOTTOM_MARGIN:  prdata = 32'(bottom_margin_reg);
            pib_pkg::REG_TOP_MARGIN:     prdata = 32'(top_margin_reg);
            default:                     prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quant_step_reg     <= 8'd20;
            width_enlarge_reg  <= 8'd0;
            length_enlarge_reg <= 8'd0;
            bottom_margin_reg  <= 8'd25;
            top_margin_reg     <= 8'd25;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                pib_pkg::REG_QUANT_STEP:     quant_step_reg     <= pwdata[7:0];
                pib_pkg::REG_WIDTH_ENLARGE:  width_enlarge_reg  <= pwdata[7:0];
                pib_pkg::REG_LENGTH_ENLARGE: length_enlarge_reg <= pwdata[7:0];
                pib_pkg::REG_BOTTOM_MARGIN:  bottom_margin_reg  <= pwdata[7:0];
                pib_pkg::REG_TOP_MARGIN:     top_margin_reg     <= pwdata[7:0];
                default:                     ;
            endcase
        end
    end

    pib_box_prep u_prep
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (prep_start),
        .pos_x          (in_ch.pos_x),
        .pos_y          (in_ch.pos_y),
        .pos_z          (in_ch.pos_z),
        .box_width      (in_ch.box_width),
        .box_length     (in_ch.box_length),
        .box_height     (in_ch.box_height),
        .heading_cos    (in_ch.heading_cos),
        .heading_sin    (in_ch.heading_sin),
        .quant_step     (quant_step_reg),
        .width_enlarge  (width_enlarge_reg),
        .length_enlarge (length_enlarge_reg),
        .done           (prep_done),
        .box            (prep_box)
    );

    assign chain[0] = launch_reg;

    for (genvar i = 0; i < MAX_BOXES; i++)
    begin : g_cell
        pib_cell #(.INDEX(i)) u_cell
        (
            .clk           (clk),
            .rst_n         (rst_n),
            .tok_in        (chain[i]),
            .bottom_margin (bottom_margin_reg),
            .top_margin    (top_margin_reg),
            .tok_out       (chain[i + 1]),
            .hit           (hit_vec[i])
        );
    end

    // Boxes past the mask width are tested but have no bit.
    for (genvar i = 0; i < MW; i++)
    begin : g_mask
        if (i < MAX_BOXES)
        begin : g_on
            assign hit_mask[i] = hit_vec[i] && (TOT_W'(i) < total_reg);
        end
        else
        begin : g_off
            assign hit_mask[i] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            total_reg    <= '0;
            wcnt_reg     <= '0;
            is_point_reg <= 1'b0;
            res_mask_reg <= '0;
            res_drop_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
            launch_reg   <= '0;
        end
        else
        begin
            launch_reg.vld <= (state_reg == S_IDLE && accept &&
                               in_ch.req_type == pib_pkg::REQ_POINT) ||
                              (state_reg == S_PREP && prep_done);
            if (state_reg == S_DONE && (!out_vld_reg || out_ch.ready))
                out_vld_reg <= 1'b1;
            else if (out_ch.ready)
                out_vld_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        res_mask_reg <= '0;
                        res_drop_reg <= 1'b0;
                        is_point_reg <= 1'b0;
                        unique case (in_ch.req_type)
                            pib_pkg::REQ_CLEAR:
                            begin
                                total_reg <= '0;
                                state_reg <= S_DONE;
                            end
                            pib_pkg::REQ_LOAD:
                            begin
                                if (full)
                                begin
                                    res_drop_reg <= 1'b1;
                                    state_reg    <= S_DONE;
                                end
                                else
                                    state_reg <= S_PREP;
                            end
                            pib_pkg::REQ_POINT:
                            begin
                                is_point_reg       <= 1'b1;
                                launch_reg.is_load <= 1'b0;
                                launch_reg.px      <= in_ch.pos_x;
                                launch_reg.py      <= in_ch.pos_y;
                                launch_reg.pz      <= in_ch.pos_z;
                                wcnt_reg           <= '0;
                                state_reg          <= S_CHAIN;
                            end
                            default: state_reg <= S_DONE;
                        endcase
                    end
                end
                S_PREP:
                begin
                    if (prep_done)
                    begin
                        launch_reg.is_load <= 1'b1;
                        launch_reg.slot    <= pib_pkg::SLOT_W'(total_reg);
                        launch_reg.box     <= prep_box;
                        launch_reg.px      <= px_reg;
                        launch_reg.py      <= py_reg;
                        launch_reg.pz      <= pz_reg;
                        total_reg          <= total_reg + TOT_W'(1);
                        wcnt_reg           <= '0;
                        state_reg          <= S_CHAIN;
                    end
                end
                S_CHAIN:
                begin
                    wcnt_reg <= wcnt_reg + WCNT_W'(1);
                    // The last cell's hit is settled once the walk count reaches WAIT_END.
                    if (wcnt_reg == WCNT_W'(WAIT_END))
                    begin
                        res_mask_reg <= is_point_reg ? hit_mask : '0;
                        state_reg    <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (!out_vld_reg || out_ch.ready)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            px_reg <= in_ch.pos_x;
            py_reg <= in_ch.pos_y;
            pz_reg <= in_ch.pos_z;
        end
        if (state_reg == S_DONE && (!out_vld_reg || out_ch.ready))
        begin
            out_mask_reg <= res_mask_reg;
            out_cnt_reg  <= (tot7 > 7'd63) ? 6'd63 : tot7[5:0];
            out_drop_reg <= res_drop_reg;
        end
    end

    assign out_ch.valid        = out_vld_reg;
    assign out_ch.hit_mask     = out_mask_reg;
    assign out_ch.boxes_stored = out_cnt_reg;
    assign out_ch.load_dropped = out_drop_reg;

endmodule

@@ sv/pib_checker.sv @@
// ----------------------------------------------------------------------------
// pib_checker: port-level checks of the oriented-box point filter
// Watches the request and result channels and the reported table state.
// ----------------------------------------------------------------------------
module pib_checker
#(
    parameter int MAX_BOXES = pib_pkg::MAX_BOXES_DEF
)
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] hit_mask,
    input logic [5:0]  boxes_stored,
    input logic        load_dropped
);

    // A waiting result beat holds its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(hit_mask) &&
        $stable(boxes_stored) && $stable(load_dropped))
        else $error("result beat changed while stalled");

    // One request at a time: after a beat is taken, the block is busy.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second request taken while one is in flight");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> 32'(boxes_stored) <= MAX_BOXES)
        else $error("table count beyond capacity");

    a_drop_no_hits: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && load_dropped |-> hit_mask == '0 && 32'(boxes_stored) == MAX_BOXES)
        else $error("dropped load with hits or a table that is not full");

    // No hit may name a slot that holds no box.
    a_hits_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && boxes_stored < 6'd32 |-> (hit_mask >> boxes_stored) == '0)
        else $error("hit reported for an empty slot");

endmodule

bind point_in_oriented_box_filter pib_checker #(.MAX_BOXES(MAX_BOXES)) u_pib_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .hit_mask     (out_ch.hit_mask),
    .boxes_stored (out_ch.boxes_stored),
    .load_dropped (out_ch.load_dropped)
);
